FILE: rtl/core/abism_pkg.sv
// ----------------------------------------------------------------------------
// abism_pkg: shared types and helpers for the A/B image install record
// Event codes, install phases, slot selectors, the record layout and the
// small helper functions used by the evaluation logic.
// ----------------------------------------------------------------------------
package abism_pkg;

	localparam int unsigned SizeW = 32;
	localparam int unsigned CrcW  = 16;
	localparam int unsigned VerW  = 32;
	localparam int unsigned SeqW  = 32;
	localparam int unsigned NumSlots = 2;

	typedef enum logic [3:0] {
		EV_SET_PENDING     = 4'd0,
		EV_INVALIDATE      = 4'd1,
		EV_BEGIN_INSTALL   = 4'd2,
		EV_FINISH_INSTALL  = 4'd3,
		EV_SET_ERROR       = 4'd4,
		EV_BEGIN_TRIAL     = 4'd5,
		EV_CONFIRM         = 4'd6,
		EV_BEGIN_ROLLBACK  = 4'd7,
		EV_FINISH_ROLLBACK = 4'd8,
		EV_ABORT_TRIAL     = 4'd9,
		EV_READ_VERSION    = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE          = 3'd0,
		PH_PENDING       = 3'd1,
		PH_INSTALLING    = 3'd2,
		PH_TRIAL_READY   = 3'd3,
		PH_TRIAL_RUNNING = 3'd4,
		PH_ROLLBACK      = 3'd5,
		PH_ERROR         = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_A    = 2'd1,
		SEL_B    = 2'd2
	} sel_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FAIL   = 2'd2
	} status_t;

	// persistent update record
	typedef struct packed {
		phase_t                         phase;
		sel_t                           active_sel;
		sel_t                           pending_sel;
		logic [NumSlots-1:0]            slot_valid;
		logic [NumSlots-1:0][SizeW-1:0] slot_size;
		logic [NumSlots-1:0][CrcW-1:0]  slot_crc;
		logic [NumSlots-1:0][VerW-1:0]  slot_version;
		logic [SeqW-1:0]                commit_seq;
		sel_t                           copy_sel;
	} record_t;

	// outcome of one event
	typedef struct packed {
		status_t         status;
		record_t         rec;
		logic [VerW-1:0] act_ver;
	} eval_res_t;

	function automatic logic is_ab(input logic [1:0] s);
		return (s == SEL_A) || (s == SEL_B);
	endfunction

	// slot B lives in entry 1, everything else maps to entry 0
	function automatic logic slot_idx(input logic [1:0] s);
		return (s == SEL_B);
	endfunction

	function automatic logic [VerW-1:0] active_ver(input record_t r);
		logic i;
		i = slot_idx(r.active_sel);
		if (is_ab(r.active_sel) && r.slot_valid[i])
			return r.slot_version[i];
		return '0;
	endfunction

endpackage

FILE: rtl/core/abism_eval.sv
// ----------------------------------------------------------------------------
// abism_eval: event evaluation
// Checks one event's preconditions against the current record and forms
// the record after the event, the status and the active image version.
// ----------------------------------------------------------------------------
module abism_eval (
	input  abism_pkg::record_t           rec,
	input  logic [3:0]                   kind,
	input  logic [1:0]                   slot,
	input  logic [abism_pkg::SizeW-1:0]  fw_size,
	input  logic [abism_pkg::CrcW-1:0]   fw_crc,
	input  logic [abism_pkg::VerW-1:0]   fw_version,
	input  logic                         commit_ok,
	output abism_pkg::eval_res_t         res
);
	import abism_pkg::*;

	record_t nx;
	record_t after;
	logic    rej;
	logic    commit;
	logic    sidx;
	logic    pidx;
	status_t st;

	assign sidx = slot_idx(slot);
	assign pidx = slot_idx(rec.pending_sel);

	// apply the event to a working copy
	always_comb begin
		nx     = rec;
		rej    = 1'b0;
		commit = 1'b1;
		unique case (kind_t'(kind))
			EV_SET_PENDING: begin
				if (fw_size == '0 || !is_ab(slot)) begin
					rej = 1'b1;
				end else begin
					nx.slot_valid[sidx]   = 1'b1;
					nx.slot_size[sidx]    = fw_size;
					nx.slot_crc[sidx]     = fw_crc;
					nx.slot_version[sidx] = fw_version;
					nx.pending_sel        = sel_t'(slot);
					nx.phase              = PH_PENDING;
				end
			end
			EV_INVALIDATE: begin
				if (!is_ab(slot)) begin
					rej = 1'b1;
				end else begin
					nx.slot_valid[sidx]   = 1'b0;
					nx.slot_size[sidx]    = '0;
					nx.slot_crc[sidx]     = '0;
					nx.slot_version[sidx] = '0;
					if (rec.pending_sel == slot) begin
						nx.pending_sel = SEL_NONE;
						nx.phase       = PH_IDLE;
					end
				end
			end
			EV_BEGIN_INSTALL: begin
				if (!is_ab(rec.pending_sel) || !rec.slot_valid[pidx] ||
						rec.slot_size[pidx] == '0) begin
					rej = 1'b1;
				end else if (rec.phase == PH_INSTALLING) begin
					commit = 1'b0;
				end else if (rec.phase != PH_PENDING) begin
					rej = 1'b1;
				end else begin
					nx.phase = PH_INSTALLING;
				end
			end
			EV_FINISH_INSTALL: begin
				if (rec.phase != PH_INSTALLING || !is_ab(rec.pending_sel))
					rej = 1'b1;
				else
					nx.phase = PH_TRIAL_READY;
			end
			EV_SET_ERROR: begin
				nx.phase = PH_ERROR;
			end
			EV_BEGIN_TRIAL: begin
				if (rec.phase != PH_TRIAL_READY || !is_ab(rec.pending_sel))
					rej = 1'b1;
				else
					nx.phase = PH_TRIAL_RUNNING;
			end
			EV_CONFIRM: begin
				if (rec.phase != PH_TRIAL_RUNNING || !is_ab(rec.pending_sel)) begin
					rej = 1'b1;
				end else begin
					nx.active_sel  = rec.pending_sel;
					nx.pending_sel = SEL_NONE;
					nx.phase       = PH_IDLE;
				end
			end
			EV_BEGIN_ROLLBACK: begin
				if (rec.phase != PH_TRIAL_RUNNING || !is_ab(rec.active_sel) ||
						!is_ab(rec.pending_sel) || rec.active_sel == rec.pending_sel)
					rej = 1'b1;
				else
					nx.phase = PH_ROLLBACK;
			end
			EV_FINISH_ROLLBACK, EV_ABORT_TRIAL: begin
				if (kind_t'(kind) == EV_FINISH_ROLLBACK) begin
					if (rec.phase != PH_ROLLBACK || !is_ab(rec.active_sel))
						rej = 1'b1;
				end else begin
					if (rec.phase != PH_TRIAL_RUNNING || rec.active_sel != SEL_NONE)
						rej = 1'b1;
				end
				if (!is_ab(rec.pending_sel))
					rej = 1'b1;
				if (!rej) begin
					nx.slot_valid[pidx]   = 1'b0;
					nx.slot_size[pidx]    = '0;
					nx.slot_crc[pidx]     = '0;
					nx.slot_version[pidx] = '0;
					nx.pending_sel        = SEL_NONE;
					nx.phase              = PH_IDLE;
				end
			end
			EV_READ_VERSION: begin
				commit = 1'b0;
			end
			default: begin
				rej = 1'b1;
			end
		endcase
	end

	// commit the working copy, or keep the old record
	always_comb begin
		after = rec;
		st    = ST_OK;
		if (rej) begin
			st = ST_REJECT;
		end else if (commit) begin
			if (commit_ok) begin
				after            = nx;
				after.commit_seq = rec.commit_seq + SeqW'(1);
				after.copy_sel   = (rec.copy_sel == SEL_A) ? SEL_B : SEL_A;
			end else begin
				st = ST_FAIL;
			end
		end
	end

	assign res.status  = st;
	assign res.rec     = after;
	assign res.act_ver = active_ver(after);

endmodule

FILE: rtl/core/abism_record.sv
// ----------------------------------------------------------------------------
// abism_record: update record storage
// Holds the install record and loads the post-event record whenever an
// event leaves the input stage.
// ----------------------------------------------------------------------------
module abism_record (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  abism_pkg::record_t rec_d,
	output abism_pkg::record_t rec_q
);
	import abism_pkg::*;

	// load the record on every processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.phase        <= PH_IDLE;
			rec_q.active_sel   <= SEL_NONE;
			rec_q.pending_sel  <= SEL_NONE;
			rec_q.slot_valid   <= '0;
			rec_q.slot_size    <= '0;
			rec_q.slot_crc     <= '0;
			rec_q.slot_version <= '0;
			rec_q.commit_seq   <= '0;
			rec_q.copy_sel     <= SEL_NONE;
		end else if (load) begin
			rec_q <= rec_d;
		end
	end

endmodule

FILE: rtl/core/ab_image_install_state_machine.sv
// ----------------------------------------------------------------------------
// ab_image_install_state_machine: A/B firmware update record keeper
// Applies install, trial, rollback and query events to the update record
// and reports status, phase, slots, sequence, copy side and active version.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_ready  | kind slot fw_size fw_crc fw_version
//           |                    | commit_ok
//   out     | out_valid/out_ready| status install_phase active_out pending_out
//           |                    | sequence_out copy_side active_version
//
// Each event is registered at the input, evaluated combinationally against the
// record and written to the result register, one event per cycle sustained
// while the receiver takes results. The record updates at the same edge as
// the result register, so the next event sees it at once.
// Reset clears the record to idle with empty slots and no copy side.
// A stalled result register holds the input stage, which then holds in_ready.
// ----------------------------------------------------------------------------
module ab_image_install_state_machine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0]                   kind,
	input  logic [1:0]                   slot,
	input  logic [abism_pkg::SizeW-1:0]  fw_size,
	input  logic [abism_pkg::CrcW-1:0]   fw_crc,
	input  logic [abism_pkg::VerW-1:0]   fw_version,
	input  logic                         commit_ok,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [2:0]                   install_phase,
	output logic [1:0]                   active_out,
	output logic [1:0]                   pending_out,
	output logic [abism_pkg::SeqW-1:0]   sequence_out,
	output logic [1:0]                   copy_side,
	output logic [abism_pkg::VerW-1:0]   active_version
);
	import abism_pkg::*;

	logic              valid_s1;
	logic [3:0]        kind_s1;
	logic [1:0]        slot_s1;
	logic [SizeW-1:0]  size_s1;
	logic [CrcW-1:0]   crc_s1;
	logic [VerW-1:0]   ver_s1;
	logic              ok_s1;

	logic              valid_s2;
	status_t           status_s2;
	phase_t            phase_s2;
	sel_t              active_s2;
	sel_t              pending_s2;
	logic [SeqW-1:0]   seq_s2;
	sel_t              copy_s2;
	logic [VerW-1:0]   ver_s2;

	logic              adv;
	record_t           rec;
	eval_res_t         res;

	// advance the input stage when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// capture the event on an input transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			slot_s1 <= slot;
			size_s1 <= fw_size;
			crc_s1  <= fw_crc;
			ver_s1  <= fw_version;
			ok_s1   <= commit_ok;
		end
	end

	abism_eval u_eval (
		.rec        (rec),
		.kind       (kind_s1),
		.slot       (slot_s1),
		.fw_size    (size_s1),
		.fw_crc     (crc_s1),
		.fw_version (ver_s1),
		.commit_ok  (ok_s1),
		.res        (res)
	);

	abism_record u_record (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.rec_d  (res.rec),
		.rec_q  (rec)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// load the result
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= res.status;
			phase_s2   <= res.rec.phase;
			active_s2  <= res.rec.active_sel;
			pending_s2 <= res.rec.pending_sel;
			seq_s2     <= res.rec.commit_seq;
			copy_s2    <= res.rec.copy_sel;
			ver_s2     <= res.act_ver;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign install_phase  = phase_s2;
	assign active_out     = active_s2;
	assign pending_out    = pending_s2;
	assign sequence_out   = seq_s2;
	assign copy_side      = copy_s2;
	assign active_version = ver_s2;

	// a rejected or failed event leaves the record untouched
	a_no_change_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.status != ST_OK) |=> $stable(rec))
		else $error("record changed after a rejected or failed event");

	// the sequence only moves on a processed event
	a_seq_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		(rec.commit_seq != $past(rec.commit_seq)) |-> $past(adv))
		else $error("commit sequence moved without an event");

	// a committed record always names a copy side
	a_copy_side_set: assert property (@(posedge clk) disable iff (!arst_n)
		(rec.commit_seq != '0) |-> (rec.copy_sel != SEL_NONE))
		else $error("committed record without a copy side");

	// a stalled result keeps the input stage occupied
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |=> (valid_s1 && $stable(kind_s1)))
		else $error("input stage lost an event during a stall");

endmodule

FILE: tb/tb_ab_image_install_state_machine.sv
// ----------------------------------------------------------------------------
// tb_ab_image_install_state_machine: self-checking bench for the A/B record
// Drives install, trial, rollback and query events through the valid/ready
// input channel and keeps its own copy of the update record. Each event's
// expected report is queued when the input transfer happens and checked
// against the next output transfer. A directed pass covers rejects, commit
// failures and each install path. A random pass runs mostly complete install
// sequences with random content, mixed with noise events. The sender works in
// bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_ab_image_install_state_machine;

	import abism_pkg::*;

	localparam int RANDOM_ITEMS      = 1600;
	localparam int PAUSE_EVERY       = 400;
	localparam int WATCHDOG_LIMIT    = 1000;
	localparam int POST_DRAIN_CYCLES = 10;
	localparam int REPORT_LIMIT      = 10;

	localparam logic [3:0] UNKNOWN_KIND_LO = 4'd11;
	localparam logic [3:0] UNKNOWN_KIND_HI = 4'd15;
	localparam logic [1:0] ILLEGAL_SLOT    = 2'd3;

	// own copy of the persistent update record
	typedef struct packed {
		phase_t                         phase;
		sel_t                           active_sel;
		sel_t                           pending_sel;
		logic [NumSlots-1:0]            valid;
		logic [NumSlots-1:0][SizeW-1:0] size;
		logic [NumSlots-1:0][CrcW-1:0]  crc;
		logic [NumSlots-1:0][VerW-1:0]  version;
		logic [SeqW-1:0]                seq;
		sel_t                           copy;
	} image_record_t;

	// one report as it leaves the block
	typedef struct packed {
		status_t         status;
		phase_t          phase;
		sel_t            active;
		sel_t            pending;
		logic [SeqW-1:0] seq;
		sel_t            copy;
		logic [VerW-1:0] act_ver;
	} event_report_t;

	class record_tracker;
		image_record_t cur;
		event_report_t expected_reports[$];
		int            failures;

		function new();
			cur      = '0;
			failures = 0;
		endfunction

		function bit names_image(logic [1:0] s);
			return (s == SEL_A) || (s == SEL_B);
		endfunction

		function int entry_of(logic [1:0] s);
			return (s == SEL_B) ? 1 : 0;
		endfunction

		function void wipe_entry(inout image_record_t r, input logic [1:0] s);
			int e;
			e = entry_of(s);
			r.valid[e]   = 1'b0;
			r.size[e]    = '0;
			r.crc[e]     = '0;
			r.version[e] = '0;
		endfunction

		// apply one accepted event and queue the report it must produce
		function void apply_event(logic [3:0] k, logic [1:0] s, logic [SizeW-1:0] sz,
				logic [CrcW-1:0] crc, logic [VerW-1:0] ver, logic ok);
			image_record_t nx;
			event_report_t rpt;
			bit            rej;
			bit            commit;
			int            e;
			nx     = cur;
			rej    = 1'b0;
			commit = 1'b1;
			case (k)
				EV_SET_PENDING: begin
					if (sz == '0 || !names_image(s)) begin
						rej = 1'b1;
					end else begin
						e             = entry_of(s);
						nx.valid[e]   = 1'b1;
						nx.size[e]    = sz;
						nx.crc[e]     = crc;
						nx.version[e] = ver;
						nx.pending_sel = sel_t'(s);
						nx.phase       = PH_PENDING;
					end
				end
				EV_INVALIDATE: begin
					if (!names_image(s)) begin
						rej = 1'b1;
					end else begin
						wipe_entry(nx, s);
						if (nx.pending_sel == s) begin
							nx.pending_sel = SEL_NONE;
							nx.phase       = PH_IDLE;
						end
					end
				end
				EV_BEGIN_INSTALL: begin
					e = entry_of(nx.pending_sel);
					if (!names_image(nx.pending_sel) || !nx.valid[e] || nx.size[e] == '0)
						rej = 1'b1;
					else if (nx.phase == PH_INSTALLING)
						commit = 1'b0;
					else if (nx.phase != PH_PENDING)
						rej = 1'b1;
					else
						nx.phase = PH_INSTALLING;
				end
				EV_FINISH_INSTALL: begin
					if (nx.phase != PH_INSTALLING || !names_image(nx.pending_sel))
						rej = 1'b1;
					else
						nx.phase = PH_TRIAL_READY;
				end
				EV_SET_ERROR: begin
					nx.phase = PH_ERROR;
				end
				EV_BEGIN_TRIAL: begin
					if (nx.phase != PH_TRIAL_READY || !names_image(nx.pending_sel))
						rej = 1'b1;
					else
						nx.phase = PH_TRIAL_RUNNING;
				end
				EV_CONFIRM: begin
					if (nx.phase != PH_TRIAL_RUNNING || !names_image(nx.pending_sel)) begin
						rej = 1'b1;
					end else begin
						nx.active_sel  = nx.pending_sel;
						nx.pending_sel = SEL_NONE;
						nx.phase       = PH_IDLE;
					end
				end
				EV_BEGIN_ROLLBACK: begin
					if (nx.phase != PH_TRIAL_RUNNING || !names_image(nx.active_sel) ||
							!names_image(nx.pending_sel) || nx.active_sel == nx.pending_sel)
						rej = 1'b1;
					else
						nx.phase = PH_ROLLBACK;
				end
				EV_FINISH_ROLLBACK, EV_ABORT_TRIAL: begin
					if (k == EV_FINISH_ROLLBACK)
						rej = (nx.phase != PH_ROLLBACK) || !names_image(nx.active_sel);
					else
						rej = (nx.phase != PH_TRIAL_RUNNING) || (nx.active_sel != SEL_NONE);
					if (!names_image(nx.pending_sel))
						rej = 1'b1;
					if (!rej) begin
						wipe_entry(nx, nx.pending_sel);
						nx.pending_sel = SEL_NONE;
						nx.phase       = PH_IDLE;
					end
				end
				EV_READ_VERSION: begin
					commit = 1'b0;
				end
				default: begin
					rej = 1'b1;
				end
			endcase

			// commit only on a passing event with a good flash write
			rpt.status = ST_OK;
			if (rej) begin
				rpt.status = ST_REJECT;
			end else if (commit) begin
				if (ok) begin
					nx.seq  = nx.seq + SeqW'(1);
					nx.copy = (nx.copy == SEL_A) ? SEL_B : SEL_A;
					cur     = nx;
				end else begin
					rpt.status = ST_FAIL;
				end
			end

			rpt.phase   = cur.phase;
			rpt.active  = cur.active_sel;
			rpt.pending = cur.pending_sel;
			rpt.seq     = cur.seq;
			rpt.copy    = cur.copy;
			e           = entry_of(cur.active_sel);
			rpt.act_ver = (names_image(cur.active_sel) && cur.valid[e]) ? cur.version[e] : '0;
			expected_reports.push_back(rpt);
		endfunction

		// compare one output transfer with the oldest queued report
		function void match_report(event_report_t got);
			event_report_t want;
			if (expected_reports.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("[%0t] unexpected result: status=%0d phase=%0d seq=%0h",
						$realtime, got.status, got.phase, got.seq);
				return;
			end
			want = expected_reports.pop_front();
			if (want !== got) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display({"[%0t] mismatch exp: st=%0d ph=%0d act=%0d pend=%0d",
						" seq=%0h cp=%0d ver=%0h"},
						$realtime, want.status, want.phase, want.active, want.pending,
						want.seq, want.copy, want.act_ver);
					$display({"[%0t]          got: st=%0d ph=%0d act=%0d pend=%0d",
						" seq=%0h cp=%0d ver=%0h"},
						$realtime, got.status, got.phase, got.active, got.pending,
						got.seq, got.copy, got.act_ver);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [3:0]        kind;
	logic [1:0]        slot;
	logic [SizeW-1:0]  fw_size;
	logic [CrcW-1:0]   fw_crc;
	logic [VerW-1:0]   fw_version;
	logic              commit_ok;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic [2:0]        install_phase;
	logic [1:0]        active_out;
	logic [1:0]        pending_out;
	logic [SeqW-1:0]   sequence_out;
	logic [1:0]        copy_side;
	logic [VerW-1:0]   active_version;

	record_tracker tracker;
	int            quiet_cycles = 0;
	int            items_sent   = 0;
	int            burst_left   = 1;
	logic [7:0]    ready_pattern = 8'hFF;
	int            pattern_age   = 0;

	ab_image_install_state_machine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.slot           (slot),
		.fw_size        (fw_size),
		.fw_crc         (fw_crc),
		.fw_version     (fw_version),
		.commit_ok      (commit_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.install_phase  (install_phase),
		.active_out     (active_out),
		.pending_out    (pending_out),
		.sequence_out   (sequence_out),
		.copy_side      (copy_side),
		.active_version (active_version)
	);

	// free-running clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sample both channels at the rising edge; count cycles with no transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.apply_event(kind, slot, fw_size, fw_crc, fw_version, commit_ok);
			if (out_valid && out_ready)
				tracker.match_report({status_t'(status), phase_t'(install_phase),
					sel_t'(active_out), sel_t'(pending_out), sequence_out,
					sel_t'(copy_side), active_version});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stall the receiver on a rotating pattern that is periodically reloaded
	always @(negedge clk) begin
		out_ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
		pattern_age++;
		if (pattern_age == 64) begin
			pattern_age = 0;
			case ($urandom_range(0, 3))
				0:       ready_pattern = 8'hFF;
				1:       ready_pattern = 8'h11;
				default: ready_pattern = 8'($urandom);
			endcase
			if (ready_pattern == 8'h00)
				ready_pattern = 8'h01;
		end
	end

	// hold valid and payload until the transfer, then idle between bursts
	task automatic send_event(input logic [3:0] k, input logic [1:0] s,
			input logic [SizeW-1:0] sz, input logic [CrcW-1:0] crc,
			input logic [VerW-1:0] ver, input logic ok);
		int gap;
		in_valid   <= 1'b1;
		kind       <= k;
		slot       <= s;
		fw_size    <= sz;
		fw_crc     <= crc;
		fw_version <= ver;
		commit_ok  <= ok;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic logic rand_ok();
		return ($urandom_range(0, 7) != 0);
	endfunction

	function automatic logic [SizeW-1:0] rand_size();
		case ($urandom_range(0, 9))
			0:       return SizeW'(1);
			1:       return '1;
			default: return SizeW'($urandom);
		endcase
	endfunction

	// control event: only commit_ok matters in the payload; randomize all of it
	task automatic send_ctrl(input logic [3:0] k);
		send_event(k, 2'($urandom_range(0, 3)), SizeW'($urandom), CrcW'($urandom),
			VerW'($urandom), rand_ok());
	endtask

	// any kind, any slot, zero size now and then
	task automatic send_noise();
		send_event(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
			($urandom_range(0, 3) == 0) ? '0 : SizeW'($urandom), CrcW'($urandom),
			VerW'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 9) == 0)
			send_noise();
	endtask

	// one well-formed install sequence with random content
	task automatic install_flow();
		logic [1:0] tgt;
		tgt = 2'($urandom_range(1, 2));
		if (tracker.names_image(tracker.cur.active_sel) && $urandom_range(0, 9) < 7)
			tgt = (tracker.cur.active_sel == SEL_A) ? SEL_B : SEL_A;
		send_event(EV_SET_PENDING, tgt, rand_size(), CrcW'($urandom), VerW'($urandom),
			rand_ok());
		maybe_noise();
		repeat ($urandom_range(1, 2)) send_ctrl(EV_BEGIN_INSTALL);
		maybe_noise();
		send_ctrl(EV_FINISH_INSTALL);
		maybe_noise();
		send_ctrl(EV_BEGIN_TRIAL);
		if ($urandom_range(0, 3) == 0)
			send_ctrl(EV_READ_VERSION);
		case ($urandom_range(0, 3))
			0, 1: send_ctrl(EV_CONFIRM);
			2: begin
				send_ctrl(EV_BEGIN_ROLLBACK);
				maybe_noise();
				send_ctrl(EV_FINISH_ROLLBACK);
			end
			default: send_ctrl(EV_ABORT_TRIAL);
		endcase
	endtask

	// stop sending until every queued report has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (tracker.expected_reports.size() != 0);
	endtask

	// end the run when the channels stay silent too long
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int next_pause;
		tracker    = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = '0;
		slot       = '0;
		fw_size    = '0;
		fw_crc     = '0;
		fw_version = '0;
		commit_ok  = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: rejects, failed commit, abort path before any confirm
		send_ctrl(EV_READ_VERSION);
		send_event(EV_SET_PENDING, SEL_A, '0, '1, '1, 1'b1);
		send_event(EV_SET_PENDING, SEL_NONE, 32'd5, '0, '0, 1'b1);
		send_event(EV_SET_PENDING, ILLEGAL_SLOT, '1, '1, '1, 1'b1);
		send_event(EV_SET_PENDING, SEL_B, '1, '1, '1, 1'b0);
		send_event(EV_SET_PENDING, SEL_B, '1, '1, '1, 1'b1);
		send_event(EV_BEGIN_INSTALL, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_BEGIN_INSTALL, SEL_NONE, '0, '0, '0, 1'b0);
		send_event(EV_FINISH_INSTALL, SEL_A, '0, '0, '0, 1'b1);
		send_event(EV_BEGIN_TRIAL, SEL_A, '0, '0, '0, 1'b1);
		send_event(EV_ABORT_TRIAL, SEL_A, '0, '0, '0, 1'b1);

		// directed: install and confirm slot A with the smallest image
		send_event(EV_SET_PENDING, SEL_A, 32'd1, '0, '0, 1'b1);
		send_event(EV_BEGIN_INSTALL, SEL_B, '1, '1, '1, 1'b1);
		send_event(EV_FINISH_INSTALL, SEL_B, '1, '1, '1, 1'b1);
		send_event(EV_BEGIN_TRIAL, SEL_B, '1, '1, '1, 1'b1);
		send_event(EV_CONFIRM, SEL_B, '1, '1, '1, 1'b1);

		// directed: trial slot B, then roll back to A
		send_event(EV_SET_PENDING, SEL_B, SizeW'($urandom), CrcW'($urandom),
			VerW'($urandom), 1'b1);
		send_event(EV_BEGIN_INSTALL, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_FINISH_INSTALL, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_BEGIN_TRIAL, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_BEGIN_ROLLBACK, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_FINISH_ROLLBACK, SEL_NONE, '0, '0, '0, 1'b1);

		// directed: invalidate, error and unknown kinds
		send_event(EV_INVALIDATE, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(EV_INVALIDATE, SEL_A, '0, '0, '0, 1'b1);
		send_event(EV_SET_ERROR, SEL_NONE, '0, '0, '0, 1'b1);
		send_event(UNKNOWN_KIND_LO, SEL_A, '0, '0, '0, 1'b1);
		send_event(UNKNOWN_KIND_HI, ILLEGAL_SLOT, '1, '1, '1, 1'b1);
		drain_results();

		// random: mostly whole install sequences, some noise
		items_sent = 0;
		next_pause = PAUSE_EVERY;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= next_pause) begin
				drain_results();
				next_pause += PAUSE_EVERY;
			end
			if ($urandom_range(0, 3) != 0)
				install_flow();
			else
				repeat ($urandom_range(1, 3)) send_noise();
		end

		// let the pipeline empty, then give the verdict
		drain_results();
		repeat (POST_DRAIN_CYCLES) @(negedge clk);
		if (tracker.failures == 0 && tracker.expected_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
